### sv/thtok_pkg.sv
`timescale 1ns / 1ps
// Package for the template hole tokenizer: beat payload types, segment and
// error codes, register indexes and character constants. No dependencies.
package thtok_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int INDEX_BITS_DEF  = 8;

  localparam logic [7:0] VALUE_MARKER_RST   = 8'd36;
  localparam logic [7:0] PATTERN_MARKER_RST = 8'd64;

  localparam logic [0:0] REG_VALUE_MARKER   = 1'b0;
  localparam logic [0:0] REG_PATTERN_MARKER = 1'b1;

  localparam logic [1:0] KIND_LITERAL = 2'd0;
  localparam logic [1:0] KIND_VALUE   = 2'd1;
  localparam logic [1:0] KIND_PATTERN = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_NONDIGIT = 2'd1;
  localparam logic [1:0] ERR_UNCLOSED = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } thtok_in_t;

  typedef struct packed {
    logic [1:0]  seg_kind;
    logic [15:0] seg_start;
    logic [15:0] seg_length;
    logic [7:0]  hole_index;
    logic        seg_final;
    logic [8:0]  match_count;
    logic [1:0]  error_code;
  } thtok_out_t;

endpackage

### sv/template_hole_tokenizer.sv
`timescale 1ns / 1ps
// Template hole tokenizer: one template byte per beat in, segment beats out.
// A beat is held in a stage register; its results, up to two, then go into the
// four-entry result queue that drives the output. One byte is taken per cycle
// while the queue has room for two; it drains one result per cycle on out_ready.
// Reset (rst_n, synchronous) restores the default markers and clears all state.
// Depends on thtok_pkg.
module template_hole_tokenizer
  import thtok_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  thtok_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output thtok_out_t out_data,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_MARKER = 2'd1;
  localparam logic [1:0] MODE_BRACE  = 2'd2;
  localparam logic [1:0] MODE_ERROR  = 2'd3;

  localparam int QPTR_W  = 2;
  localparam int Q_DEPTH = 1 << QPTR_W;
  localparam logic [QPTR_W:0] Q_ROOM = (QPTR_W + 1)'(Q_DEPTH - 2);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  function automatic logic [15:0] fit16(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+15:0] w;
    w = (OFFSET_BITS + 16)'(v);
    return w[15:0];
  endfunction

  function automatic logic [7:0] fit8(input logic [INDEX_BITS-1:0] v);
    logic [INDEX_BITS+7:0] w;
    w = (INDEX_BITS + 8)'(v);
    return w[7:0];
  endfunction

  function automatic logic [8:0] fit9(input logic [INDEX_BITS:0] v);
    logic [INDEX_BITS+9:0] w;
    w = (INDEX_BITS + 10)'(v);
    return w[8:0];
  endfunction

  function automatic thtok_out_t mk_res(
    input logic [1:0]             kind,
    input logic [OFFSET_BITS-1:0] start,
    input logic [OFFSET_BITS-1:0] len,
    input logic [INDEX_BITS-1:0]  idx,
    input logic                   fin,
    input logic [INDEX_BITS:0]    cnt,
    input logic [1:0]             err
  );
    thtok_out_t r;
    r.seg_kind    = kind;
    r.seg_start   = fit16(start);
    r.seg_length  = fit16(len);
    r.hole_index  = fit8(idx);
    r.seg_final   = fin;
    r.match_count = fit9(cnt);
    r.error_code  = err;
    return r;
  endfunction

  logic [7:0]             vmark_r, pmark_r;
  logic                   s1_valid_r, s1_valid_nxt;
  thtok_in_t              s1_data_r;
  logic                   go;

  logic [1:0]             mode_r, mode_nxt;
  logic                   pat_r, pat_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] lstart_r, lstart_nxt;
  logic [OFFSET_BITS-1:0] llen_r, llen_nxt;
  logic [INDEX_BITS-1:0]  idx_r, idx_nxt;
  logic [INDEX_BITS:0]    maxc_r, maxc_nxt;
  logic [1:0]             herr_r, herr_nxt;

  thtok_out_t             res_v [2];
  logic [1:0]             nres;

  thtok_out_t             q_r [Q_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]        cnt_r;
  logic                   pop;

  assign in_ready  = !s1_valid_r || (cnt_r <= Q_ROOM);
  assign go        = s1_valid_r && (cnt_r <= Q_ROOM);
  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    logic [7:0]             c;
    logic                   fin;
    logic [7:0]             first;
    logic [7:0]             dsub;
    logic [INDEX_BITS+3:0]  prod;
    logic [INDEX_BITS:0]    cand;
    logic [OFFSET_BITS-1:0] len_v;
    logic                   do_normal;

    c         = s1_data_r.text_byte;
    fin       = s1_data_r.final_byte;
    first     = pat_r ? pmark_r : vmark_r;
    dsub      = c - CH_ZERO;
    prod      = ((INDEX_BITS + 4)'(idx_r) << 3) + ((INDEX_BITS + 4)'(idx_r) << 1)
                + (INDEX_BITS + 4)'(dsub[3:0]);
    cand      = (INDEX_BITS + 1)'(idx_r) + 1'b1;
    len_v     = llen_r;
    do_normal = 1'b0;

    mode_nxt   = mode_r;
    pat_nxt    = pat_r;
    off_nxt    = off_r;
    lstart_nxt = lstart_r;
    llen_nxt   = llen_r;
    idx_nxt    = idx_r;
    maxc_nxt   = maxc_r;
    herr_nxt   = herr_r;
    nres       = 2'd0;
    res_v[0]   = '0;
    res_v[1]   = '0;

    if (go) begin
      if (off_r != OFF_MAX) begin
        off_nxt = off_r + 1'b1;
      end
      if (mode_r == MODE_ERROR) begin
        if (fin) begin
          res_v[nres[0]] = mk_res(KIND_LITERAL, '0, '0, '0, 1'b1, maxc_r, herr_r);
          nres = nres + 2'd1;
        end
      end else if (off_r == OFF_MAX) begin
        mode_nxt = MODE_ERROR;
        herr_nxt = ERR_OVERFLOW;
        if (fin) begin
          res_v[nres[0]] = mk_res(KIND_LITERAL, '0, '0, '0, 1'b1, maxc_r, ERR_OVERFLOW);
          nres = nres + 2'd1;
        end
      end else begin
        case (mode_r)
          MODE_MARKER: begin
            if (c == first || c == CH_LBRACE) begin
              if (llen_r != '0) begin
                res_v[nres[0]] = mk_res(KIND_LITERAL, lstart_r, llen_r, '0, 1'b0, '0,
                                        ERR_NONE);
                nres = nres + 2'd1;
              end
            end
            if (c == first) begin
              lstart_nxt = off_r;
              llen_nxt   = OFFSET_BITS'(1);
              mode_nxt   = MODE_NORMAL;
              if (fin) begin
                res_v[nres[0]] = mk_res(KIND_LITERAL, off_r, OFFSET_BITS'(1), '0, 1'b1,
                                        maxc_r, ERR_NONE);
                nres = nres + 2'd1;
              end
            end else if (c == CH_LBRACE) begin
              llen_nxt = '0;
              idx_nxt  = '0;
              mode_nxt = MODE_BRACE;
              if (fin) begin
                mode_nxt = MODE_ERROR;
                herr_nxt = ERR_UNCLOSED;
                res_v[nres[0]] = mk_res(KIND_LITERAL, '0, '0, '0, 1'b1, maxc_r,
                                        ERR_UNCLOSED);
                nres = nres + 2'd1;
              end
            end else begin
              len_v     = llen_r + 1'b1;
              mode_nxt  = MODE_NORMAL;
              do_normal = 1'b1;
            end
          end
          MODE_BRACE: begin
            if (c == CH_RBRACE) begin
              if (pat_r) begin
                if (cand > maxc_r) begin
                  maxc_nxt = cand;
                end
                res_v[nres[0]] = mk_res(KIND_PATTERN, '0, '0, idx_r, 1'b0, '0, ERR_NONE);
              end else begin
                res_v[nres[0]] = mk_res(KIND_VALUE, '0, '0, idx_r, 1'b0, '0, ERR_NONE);
              end
              nres       = nres + 2'd1;
              lstart_nxt = off_r + 1'b1;
              llen_nxt   = '0;
              mode_nxt   = MODE_NORMAL;
              if (fin) begin
                res_v[nres[0]] = mk_res(KIND_LITERAL, off_r + 1'b1, '0, '0, 1'b1,
                                        maxc_nxt, ERR_NONE);
                nres = nres + 2'd1;
              end
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
              if (prod[INDEX_BITS+3:INDEX_BITS] != '0) begin
                mode_nxt = MODE_ERROR;
                herr_nxt = ERR_OVERFLOW;
                if (fin) begin
                  res_v[nres[0]] = mk_res(KIND_LITERAL, '0, '0, '0, 1'b1, maxc_r,
                                          ERR_OVERFLOW);
                  nres = nres + 2'd1;
                end
              end else begin
                idx_nxt = prod[INDEX_BITS-1:0];
                if (fin) begin
                  mode_nxt = MODE_ERROR;
                  herr_nxt = ERR_UNCLOSED;
                  res_v[nres[0]] = mk_res(KIND_LITERAL, '0, '0, '0, 1'b1, maxc_r,
                                          ERR_UNCLOSED);
                  nres = nres + 2'd1;
                end
              end
            end else begin
              mode_nxt = MODE_ERROR;
              herr_nxt = ERR_NONDIGIT;
              if (fin) begin
                res_v[nres[0]] = mk_res(KIND_LITERAL, '0, '0, '0, 1'b1, maxc_r,
                                        ERR_NONDIGIT);
                nres = nres + 2'd1;
              end
            end
          end
          default: begin
            do_normal = 1'b1;
          end
        endcase

        if (do_normal) begin
          if ((c == vmark_r || c == pmark_r) && !fin) begin
            mode_nxt = MODE_MARKER;
            pat_nxt  = (c != vmark_r);
            llen_nxt = len_v;
          end else begin
            llen_nxt = len_v + 1'b1;
            if (fin) begin
              res_v[nres[0]] = mk_res(KIND_LITERAL, lstart_r, len_v + 1'b1, '0, 1'b1,
                                      maxc_r, ERR_NONE);
              nres = nres + 2'd1;
            end
          end
        end
      end

      if (fin) begin
        mode_nxt   = MODE_NORMAL;
        pat_nxt    = 1'b0;
        off_nxt    = '0;
        lstart_nxt = '0;
        llen_nxt   = '0;
        idx_nxt    = '0;
        maxc_nxt   = '0;
        herr_nxt   = ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmark_r <= VALUE_MARKER_RST;
      pmark_r <= PATTERN_MARKER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VALUE_MARKER:   vmark_r <= cfg_wdata;
        REG_PATTERN_MARKER: pmark_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      mode_r     <= MODE_NORMAL;
      pat_r      <= 1'b0;
      off_r      <= '0;
      lstart_r   <= '0;
      llen_r     <= '0;
      idx_r      <= '0;
      maxc_r     <= '0;
      herr_r     <= ERR_NONE;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      mode_r     <= mode_nxt;
      pat_r      <= pat_nxt;
      off_r      <= off_nxt;
      lstart_r   <= lstart_nxt;
      llen_r     <= llen_nxt;
      idx_r      <= idx_nxt;
      maxc_r     <= maxc_nxt;
      herr_r     <= herr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (nres != 2'd0) begin
      q_r[wr_ptr_r] <= res_v[0];
    end
    if (nres == 2'd2) begin
      q_r[wr_ptr_r + 1'b1] <= res_v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(nres);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPTR_W + 1)'(nres) - (QPTR_W + 1)'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W + 1)'(Q_DEPTH))
    else $error("result queue count exceeds its depth");

  a_error_held: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_ERROR |-> herr_r != ERR_NONE)
    else $error("error mode without a held error code");

  a_second_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    nres == 2'd2 |-> res_v[1].seg_final)
    else $error("second result of a byte is not the final segment");

  a_error_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    (nres != 2'd0 && !res_v[0].seg_final) |-> res_v[0].error_code == ERR_NONE)
    else $error("error code on a segment that is not final");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (go && s1_data_r.final_byte) |=> (mode_r == MODE_NORMAL && off_r == '0))
    else $error("state not restarted after the last byte");
`endif

endmodule

### sim/tb_template_hole_tokenizer.sv
`timescale 1ns / 1ps
// Self-checking testbench for template_hole_tokenizer: directed templates, then random
// templates under several marker settings, checked beat by beat against a tokenizer model.
// Depends on thtok_pkg and template_hole_tokenizer.
module tb_template_hole_tokenizer;
  import thtok_pkg::*;

  localparam int unsigned OFF_LIMIT = (1 << OFFSET_BITS_DEF) - 1;
  localparam int unsigned IDX_LIMIT = (1 << INDEX_BITS_DEF) - 1;
  localparam int PHASE_BYTES = 210;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef enum logic [1:0] {SCAN_TEXT, SCAN_MARKER, SCAN_BRACE, SCAN_ERROR} scan_state_t;

  typedef struct packed {
    logic [7:0] text;
    logic       fin;
    logic       typed;
    thtok_out_t want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  thtok_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  thtok_out_t out_data;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_VALUE_MARKER;
  logic [7:0] cfg_wdata = '0;

  logic [7:0]  mk_value = VALUE_MARKER_RST;
  logic [7:0]  mk_pattern = PATTERN_MARKER_RST;
  scan_state_t tok_state;
  logic        hole_is_pat;
  int unsigned pos_next;
  int unsigned run_from;
  int unsigned run_bytes;
  int unsigned idx_sum;
  int unsigned pat_count;
  logic [1:0]  err_held;

  thtok_out_t pending_segs[$];
  dir_row_t   dir_table[$];
  logic [7:0] tpl_bytes[$];
  bit         idle_on = 1'b1;
  int         fail_count = 0;
  int         cycle_count = 0;
  int         stall_left = 0;

  template_hole_tokenizer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic thtok_out_t make_seg(input logic [1:0] kind, input int unsigned start,
                                          input int unsigned len, input int unsigned idx,
                                          input logic fin, input int unsigned count,
                                          input logic [1:0] err);
    thtok_out_t s;
    s.seg_kind    = kind;
    s.seg_start   = 16'(start);
    s.seg_length  = 16'(len);
    s.hole_index  = 8'(idx);
    s.seg_final   = fin;
    s.match_count = 9'(count);
    s.error_code  = err;
    return s;
  endfunction

  function automatic dir_row_t row_of(input logic [7:0] text, input logic fin,
                                      input logic typed = 1'b0, input thtok_out_t want = '0);
    dir_row_t r;
    r.text  = text;
    r.fin   = fin;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  task automatic clear_scan();
    tok_state   = SCAN_TEXT;
    hole_is_pat = 1'b0;
    pos_next    = 0;
    run_from    = 0;
    run_bytes   = 0;
    idx_sum     = 0;
    pat_count   = 0;
    err_held    = ERR_NONE;
  endtask

  task automatic flush_run();
    if (run_bytes != 0) begin
      pending_segs.push_back(make_seg(KIND_LITERAL, run_from, run_bytes, 0, 1'b0, 0, ERR_NONE));
    end
  endtask

  task automatic finish_run();
    pending_segs.push_back(make_seg(KIND_LITERAL, run_from, run_bytes, 0, 1'b1, pat_count,
                                    ERR_NONE));
  endtask

  task automatic trip_error(input logic [1:0] code, input logic fin);
    tok_state = SCAN_ERROR;
    err_held  = code;
    if (fin) begin
      pending_segs.push_back(make_seg(KIND_LITERAL, 0, 0, 0, 1'b1, pat_count, code));
    end
  endtask

  task automatic take_plain(input logic [7:0] c, input logic fin);
    if ((c == mk_value || c == mk_pattern) && !fin) begin
      tok_state   = SCAN_MARKER;
      hole_is_pat = (c != mk_value);
    end else begin
      run_bytes++;
      if (fin) finish_run();
    end
  endtask

  task automatic tokenize_byte(input logic [7:0] c, input logic fin);
    int unsigned here;
    int unsigned next_idx;
    logic [7:0]  opener;
    here = pos_next;
    if (pos_next < OFF_LIMIT) pos_next++;
    if (tok_state == SCAN_ERROR) begin
      if (fin) begin
        pending_segs.push_back(make_seg(KIND_LITERAL, 0, 0, 0, 1'b1, pat_count, err_held));
      end
    end else if (here >= OFF_LIMIT) begin
      trip_error(ERR_OVERFLOW, fin);
    end else if (tok_state == SCAN_MARKER) begin
      opener = hole_is_pat ? mk_pattern : mk_value;
      if (c == opener) begin
        flush_run();
        run_from  = here;
        run_bytes = 1;
        tok_state = SCAN_TEXT;
        if (fin) finish_run();
      end else if (c == CH_LBRACE) begin
        flush_run();
        run_bytes = 0;
        idx_sum   = 0;
        tok_state = SCAN_BRACE;
        if (fin) trip_error(ERR_UNCLOSED, 1'b1);
      end else begin
        run_bytes++;
        tok_state = SCAN_TEXT;
        take_plain(c, fin);
      end
    end else if (tok_state == SCAN_BRACE) begin
      if (c == CH_RBRACE) begin
        if (hole_is_pat) begin
          if (idx_sum + 1 > pat_count) pat_count = idx_sum + 1;
          pending_segs.push_back(make_seg(KIND_PATTERN, 0, 0, idx_sum, 1'b0, 0, ERR_NONE));
        end else begin
          pending_segs.push_back(make_seg(KIND_VALUE, 0, 0, idx_sum, 1'b0, 0, ERR_NONE));
        end
        run_from  = here + 1;
        run_bytes = 0;
        tok_state = SCAN_TEXT;
        if (fin) finish_run();
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        next_idx = idx_sum * 10 + int'(c - CH_ZERO);
        if (next_idx > IDX_LIMIT) begin
          trip_error(ERR_OVERFLOW, fin);
        end else begin
          idx_sum = next_idx;
          if (fin) trip_error(ERR_UNCLOSED, 1'b1);
        end
      end else begin
        trip_error(ERR_NONDIGIT, fin);
      end
    end else begin
      take_plain(c, fin);
    end
    if (fin) clear_scan();
  endtask

  task automatic send_byte(input logic [7:0] text, input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {text, fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tokenize_byte(text, fin);
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_markers(input logic [7:0] value_mk, input logic [7:0] pattern_mk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_VALUE_MARKER;
    cfg_wdata <= value_mk;
    @(posedge clk);
    cfg_index <= REG_PATTERN_MARKER;
    cfg_wdata <= pattern_mk;
    @(posedge clk);
    cfg_we     <= 1'b0;
    mk_value   = value_mk;
    mk_pattern = pattern_mk;
  endtask

  task automatic build_template();
    int         sel;
    logic [7:0] m;
    tpl_bytes.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 10)) tpl_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        m   = $urandom_range(0, 1) ? mk_pattern : mk_value;
        sel = $urandom_range(0, 9);
        case (sel)
          0, 1, 2: begin
            repeat ($urandom_range(1, 4)) tpl_bytes.push_back(8'($urandom));
          end
          3: begin
            tpl_bytes.push_back(m);
            tpl_bytes.push_back(m);
          end
          7: begin
            tpl_bytes.push_back(m);
            tpl_bytes.push_back(8'($urandom));
          end
          8: begin
            tpl_bytes.push_back(m);
            tpl_bytes.push_back(CH_LBRACE);
            tpl_bytes.push_back(8'($urandom));
          end
          default: begin
            tpl_bytes.push_back(m);
            tpl_bytes.push_back(CH_LBRACE);
            repeat ($urandom_range(0, 3)) begin
              tpl_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            if (sel != 9) tpl_bytes.push_back(CH_RBRACE);
          end
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : seg_check
    thtok_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_segs.size() == 0) begin
        $error("segment beat with nothing expected: %p", out_data);
        fail_count++;
      end else begin
        want = pending_segs.pop_front();
        if (out_data.seg_kind !== want.seg_kind) begin
          $error("seg_kind: expected %0d, got %0d", want.seg_kind, out_data.seg_kind);
          fail_count++;
        end
        if (out_data.seg_start !== want.seg_start) begin
          $error("seg_start: expected %0d, got %0d", want.seg_start, out_data.seg_start);
          fail_count++;
        end
        if (out_data.seg_length !== want.seg_length) begin
          $error("seg_length: expected %0d, got %0d", want.seg_length, out_data.seg_length);
          fail_count++;
        end
        if (out_data.hole_index !== want.hole_index) begin
          $error("hole_index: expected %0d, got %0d", want.hole_index, out_data.hole_index);
          fail_count++;
        end
        if (out_data.seg_final !== want.seg_final) begin
          $error("seg_final: expected %0d, got %0d", want.seg_final, out_data.seg_final);
          fail_count++;
        end
        if (out_data.match_count !== want.match_count) begin
          $error("match_count: expected %0d, got %0d", want.match_count,
                 out_data.match_count);
          fail_count++;
        end
        if (out_data.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_data.error_code);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int sent;
    clear_scan();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    dir_table = '{
      row_of(PATTERN_MARKER_RST, 1'b0),
      row_of(CH_LBRACE, 1'b0),
      row_of(CH_ZERO + 8'd2, 1'b0),
      row_of(CH_ZERO + 8'd5, 1'b0),
      row_of(CH_ZERO + 8'd5, 1'b0),
      row_of(CH_RBRACE, 1'b0),
      row_of(8'hFF, 1'b1, 1'b1, make_seg(KIND_LITERAL, 6, 1, 0, 1'b1, 256, ERR_NONE)),
      row_of(VALUE_MARKER_RST, 1'b0),
      row_of(VALUE_MARKER_RST, 1'b1, 1'b1, make_seg(KIND_LITERAL, 1, 1, 0, 1'b1, 0, ERR_NONE)),
      row_of(VALUE_MARKER_RST, 1'b0),
      row_of(8'h00, 1'b0),
      row_of(PATTERN_MARKER_RST, 1'b1, 1'b1,
             make_seg(KIND_LITERAL, 0, 3, 0, 1'b1, 0, ERR_NONE)),
      row_of(VALUE_MARKER_RST, 1'b0),
      row_of(CH_LBRACE, 1'b0),
      row_of(CH_RBRACE, 1'b1),
      row_of(PATTERN_MARKER_RST, 1'b0),
      row_of(CH_LBRACE, 1'b0),
      row_of("a", 1'b0),
      row_of("z", 1'b1, 1'b1, make_seg(KIND_LITERAL, 0, 0, 0, 1'b1, 0, ERR_NONDIGIT)),
      row_of(VALUE_MARKER_RST, 1'b0),
      row_of(CH_LBRACE, 1'b1, 1'b1, make_seg(KIND_LITERAL, 0, 0, 0, 1'b1, 0, ERR_UNCLOSED)),
      row_of(VALUE_MARKER_RST, 1'b0),
      row_of(CH_LBRACE, 1'b0),
      row_of(CH_ZERO + 8'd2, 1'b0),
      row_of(CH_ZERO + 8'd5, 1'b0),
      row_of(CH_ZERO + 8'd6, 1'b1, 1'b1, make_seg(KIND_LITERAL, 0, 0, 0, 1'b1, 0, ERR_OVERFLOW))
    };

    foreach (dir_table[i]) begin
      send_byte(dir_table[i].text, dir_table[i].fin);
      if (dir_table[i].typed) begin
        void'(pending_segs.pop_back());
        pending_segs.push_back(dir_table[i].want);
      end
    end
    wait_drained(SETTLE_CYCLES);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_markers(8'h00, 8'hFF);
        1: set_markers(8'hFF, 8'h00);
        2: set_markers("#", "#");
        3: set_markers(8'($urandom), 8'($urandom));
        default: set_markers(VALUE_MARKER_RST, PATTERN_MARKER_RST);
      endcase

      sent = 0;
      while (sent < PHASE_BYTES) begin
        idle_on = (ph != 4) && ($urandom_range(0, 4) != 0);
        build_template();
        foreach (tpl_bytes[i]) send_byte(tpl_bytes[i], i == tpl_bytes.size() - 1);
        sent += tpl_bytes.size();
      end
      wait_drained(SETTLE_CYCLES);
    end

    wait_drained(2 * SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
